FILE: hw/rtl/rms_pkg.sv
// Package for the rate-monotonic scheduler: payload types, event codes, table size.
// No dependencies.
package rms_pkg;

  localparam int unsigned TableDepth = 8;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam logic [30:0] TimeMax = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    EV_START    = 3'd0,
    EV_RESUME   = 3'd1,
    EV_PREEMPT  = 3'd2,
    EV_COMPLETE = 3'd3,
    EV_MISS     = 3'd4,
    EV_IDLE     = 3'd5,
    EV_DONE     = 3'd6,
    EV_OVERFLOW = 3'd7
  } event_e;

  typedef enum logic {
    FN_RELEASE = 1'b0,
    FN_FINISH  = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [15:0] task_id;
    logic [15:0] exec_time;
    logic [15:0] period;
    logic [30:0] arrival;
  } req_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [15:0]        job_task_id;
    logic [30:0]        event_time;
    logic signed [31:0] waiting;
    logic               last;
  } res_t;

endpackage

FILE: hw/rtl/rms_if.sv
// Valid/ready channel carrying one payload per transaction.
// Depends on rms_pkg.
interface rms_req_if;
  logic          valid;
  logic          ready;
  rms_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rms_res_if;
  logic          valid;
  logic          ready;
  rms_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rate_monotonic_scheduler_top.sv
// Rate-monotonic scheduler: a sequencer walks the ready table one slot a cycle through a shared
// compare unit, one input transaction at a time. A release at the current time is stored directly;
// a release that moves time first runs jobs up to its arrival and sweeps for missed deadlines;
// a finish runs every job to completion. A held output stalls the sequencer.
// Reset clears time, valid bits, running slot and age counter; slot contents are not cleared.
// Depends on rms_pkg and rms_if.
module rate_monotonic_scheduler_top (
  input logic      clk_i,
  input logic      rst_ni,
  rms_req_if.sink  req_i,
  rms_res_if.source res_o
);

  localparam int unsigned D = rms_pkg::TableDepth;
  localparam int unsigned SW = rms_pkg::SlotW;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_START, S_RUN, S_SWEEP, S_STORE, S_DONE, S_EMIT
  } state_e;

  state_e state_q, ret_q;
  rms_pkg::req_t req_q;
  logic [30:0] now_q;
  logic [D-1:0] valid_q;
  logic [15:0] task_q [D];
  logic [15:0] rem_q [D];
  logic [15:0] exec_q [D];
  logic [15:0] per_q [D];
  logic [30:0] arr_q [D];
  logic [D-1:0] intr_q;
  logic [15:0] age_q [D];
  logic run_v_q;
  logic [SW-1:0] run_q;
  logic [15:0] agec_q;
  logic [SW-1:0] idx_q;
  logic best_v_q;
  logic [SW-1:0] best_q;
  logic dispatch_q; // scan result drives a start only (after completion)
  logic out_v_q;
  rms_pkg::res_t out_q;

  wire [SW-1:0] ix = idx_q;
  wire bounded = (req_q.func == rms_pkg::FN_RELEASE);

  // shared compare: does slot ix beat current best
  logic beats;
  always_comb begin
    beats = 1'b0;
    if (valid_q[ix]) begin
      if (!best_v_q || per_q[ix] < per_q[best_q]) beats = 1'b1;
      else if (per_q[ix] == per_q[best_q] && !(run_v_q && best_q == run_q)) begin
        if ((run_v_q && ix == run_q) ||
            (16'(agec_q - age_q[ix]) > 16'(agec_q - age_q[best_q]))) beats = 1'b1;
      end
    end
  end

  logic [31:0] endt;
  assign endt = {1'b0, now_q} + {16'd0, rem_q[run_q]};
  logic [31:0] deadl;
  assign deadl = {1'b0, arr_q[ix]} + {16'd0, per_q[ix]};

  function automatic logic [31:0] wait_f(logic [30:0] t, logic [30:0] a, logic [15:0] e);
    return {1'b0, t} - {1'b0, a} - {16'd0, e};
  endfunction

  logic [SW-1:0] free_ix;
  logic free_v;
  always_comb begin
    free_v = 1'b0;
    free_ix = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_v = 1'b1;
        free_ix = SW'(i);
      end
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_v_q;
  assign res_o.data = out_q;
  wire out_free = !out_v_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      now_q <= '0;
      valid_q <= '0;
      run_v_q <= 1'b0;
      run_q <= '0;
      agec_q <= '0;
      out_v_q <= 1'b0;
      idx_q <= '0;
      best_v_q <= 1'b0;
      best_q <= '0;
      dispatch_q <= 1'b0;
    end else begin
      logic out_v_d;
      out_v_d = out_v_q && !res_o.ready;
      case (state_q)
        S_IDLE: if (req_i.valid) begin
          rms_pkg::req_t req_d;
          req_d = req_i.data;
          if (req_i.data.func == rms_pkg::FN_FINISH) begin
            idx_q <= '0; best_v_q <= 1'b0; dispatch_q <= 1'b0; state_q <= S_SCAN;
          end else begin
            if (req_i.data.arrival <= now_q) begin
              req_d.arrival = now_q;
              state_q <= S_STORE;
            end else begin
              idx_q <= '0; best_v_q <= 1'b0; dispatch_q <= 1'b0; state_q <= S_SCAN;
            end
          end
          req_q <= req_d;
        end
        S_SCAN: begin
          if (beats) begin best_v_q <= 1'b1; best_q <= ix; end
          if (idx_q == SW'(D - 1)) state_q <= dispatch_q ? S_START : S_DECIDE;
          else idx_q <= idx_q + 1'b1;
        end
        S_DECIDE: if (out_free) begin
          if (run_v_q && best_q != run_q) begin
            out_v_d = 1'b1;
            out_q <= '{rms_pkg::EV_PREEMPT, task_q[run_q], now_q, 32'sd0, 1'b0};
            intr_q[run_q] <= 1'b1;
            age_q[run_q] <= agec_q;
            agec_q <= agec_q + 16'd1;
            run_v_q <= 1'b0;
            state_q <= S_START;
          end else state_q <= run_v_q ? S_RUN : S_START;
        end
        S_START: if (out_free) begin
          if (!run_v_q && best_v_q) begin
            out_v_d = 1'b1;
            out_q <= '{intr_q[best_q] ? rms_pkg::EV_RESUME : rms_pkg::EV_START,
                       task_q[best_q], now_q, 32'sd0, 1'b0};
            intr_q[best_q] <= 1'b0;
            run_v_q <= 1'b1;
            run_q <= best_q;
          end
          state_q <= S_RUN;
        end
        S_RUN: if (out_free) begin
          if (!run_v_q) begin
            if (bounded && now_q < req_q.arrival) begin
              now_q <= req_q.arrival;
              out_v_d = 1'b1;
              out_q <= '{rms_pkg::EV_IDLE, 16'd0, req_q.arrival, 32'sd0, 1'b0};
            end
            idx_q <= '0;
            state_q <= bounded ? S_SWEEP : S_DONE;
          end else if (!bounded || endt <= {1'b0, req_q.arrival}) begin
            logic [30:0] t;
            t = endt[31] ? rms_pkg::TimeMax : endt[30:0];
            now_q <= t;
            out_v_d = 1'b1;
            out_q <= '{rms_pkg::EV_COMPLETE, task_q[run_q], t,
                       wait_f(t, arr_q[run_q], exec_q[run_q]), 1'b0};
            valid_q[run_q] <= 1'b0;
            run_v_q <= 1'b0;
            idx_q <= '0; best_v_q <= 1'b0; dispatch_q <= 1'b1;
            state_q <= S_SCAN;
          end else begin
            rem_q[run_q] <= rem_q[run_q] - 16'(req_q.arrival - now_q);
            now_q <= req_q.arrival;
            idx_q <= '0;
            state_q <= S_SWEEP;
          end
        end
        S_SWEEP: if (out_free) begin
          if (valid_q[ix] && deadl <= {1'b0, now_q}) begin
            out_v_d = 1'b1;
            out_q <= '{rms_pkg::EV_MISS, task_q[ix], now_q,
                       wait_f(now_q, arr_q[ix], exec_q[ix]), 1'b0};
            valid_q[ix] <= 1'b0;
            if (run_v_q && run_q == ix) run_v_q <= 1'b0;
          end
          if (idx_q == SW'(D - 1)) state_q <= S_STORE;
          else idx_q <= idx_q + 1'b1;
        end
        S_STORE: if (out_free) begin
          if (!free_v) begin
            out_v_d = 1'b1;
            out_q <= '{rms_pkg::EV_OVERFLOW, req_q.task_id, now_q, 32'sd0, 1'b0};
          end else begin
            valid_q[free_ix] <= 1'b1;
            task_q[free_ix] <= req_q.task_id;
            rem_q[free_ix] <= req_q.exec_time;
            exec_q[free_ix] <= req_q.exec_time;
            per_q[free_ix] <= req_q.period;
            arr_q[free_ix] <= req_q.arrival;
            intr_q[free_ix] <= 1'b0;
            age_q[free_ix] <= agec_q;
            agec_q <= agec_q + 16'd1;
          end
          state_q <= S_IDLE;
        end
        S_DONE: if (out_free) begin
          out_v_d = 1'b1;
          out_q <= '{rms_pkg::EV_DONE, 16'd0, now_q, 32'sd0, 1'b1};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      out_v_q <= out_v_d;
      ret_q <= state_q;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !run_v_q || valid_q[run_q])
    else $error("running slot not valid while idle");
  a_time_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    now_q >= $past(now_q) || ret_q == S_IDLE)
    else $error("time went backwards");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !res_o.ready |=> out_v_q && $stable(out_q))
    else $error("result dropped under stall");

endmodule

FILE: tb/rms_tb_pkg.sv
// Scoreboard for the rate-monotonic scheduler testbench: a schedule predictor
// and a queue of expected events. Depends on rms_pkg.
package rms_tb_pkg;

  class sched_scoreboard;
    localparam int NoSlot = -1;

    // predictor state
    bit [30:0] cur_time;
    bit        valid_q [rms_pkg::TableDepth];
    bit [15:0] task_q  [rms_pkg::TableDepth];
    bit [15:0] remain_q[rms_pkg::TableDepth];
    bit [15:0] exec_q  [rms_pkg::TableDepth];
    bit [15:0] period_q[rms_pkg::TableDepth];
    bit [30:0] arr_q   [rms_pkg::TableDepth];
    bit        intr_q  [rms_pkg::TableDepth];
    bit [15:0] age_q   [rms_pkg::TableDepth];
    int        running;
    bit [15:0] age_cnt;

    rms_pkg::res_t pending_events[$];
    int        errors;
    int        n_checked;
    int        n_miss, n_preempt, n_overflow;

    function new();
      cur_time = '0;
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      running = NoSlot;
      age_cnt = '0;
      errors = 0;
      n_checked = 0;
      n_miss = 0;
      n_preempt = 0;
      n_overflow = 0;
    endfunction

    function void push_event(rms_pkg::event_e ev, bit [15:0] tid, bit [30:0] t,
                             bit [31:0] w, bit lst);
      rms_pkg::res_t r;
      r.event_res   = ev;
      r.job_task_id = tid;
      r.event_time  = t;
      r.waiting     = w;
      r.last        = lst;
      pending_events.insert(pending_events.size(), r);
    endfunction

    function bit [31:0] wait_of(int s);
      return {1'b0, cur_time} - {1'b0, arr_q[s]} - {16'd0, exec_q[s]};
    endfunction

    function bit [15:0] age_dist(int s);
      return age_cnt - age_q[s];
    endfunction

    function bit [15:0] take_stamp();
      take_stamp = age_cnt;
      age_cnt++;
    endfunction

    function int pick_slot();
      int b;
      b = NoSlot;
      for (int i = 0; i < rms_pkg::TableDepth; i++) begin
        if (!valid_q[i]) continue;
        if (b == NoSlot || period_q[i] < period_q[b]) begin
          b = i;
        end else if (period_q[i] == period_q[b] && b != running) begin
          if (i == running || age_dist(i) > age_dist(b)) b = i;
        end
      end
      return b;
    endfunction

    function void dispatch(int s);
      push_event(intr_q[s] ? rms_pkg::EV_RESUME : rms_pkg::EV_START, task_q[s], cur_time,
                 '0, 1'b0);
      intr_q[s] = 1'b0;
      running = s;
    endfunction

    function void advance(bit [31:0] target, bit bounded);
      int b, r;
      bit [32:0] fin;
      b = pick_slot();
      if (running != NoSlot && b != running) begin
        push_event(rms_pkg::EV_PREEMPT, task_q[running], cur_time, '0, 1'b0);
        intr_q[running] = 1'b1;
        age_q[running] = take_stamp();
        running = NoSlot;
        n_preempt++;
      end
      if (running == NoSlot && b != NoSlot) dispatch(b);
      forever begin
        r = running;
        if (r == NoSlot) begin
          if (bounded && cur_time < target) begin
            cur_time = target[30:0];
            push_event(rms_pkg::EV_IDLE, '0, cur_time, '0, 1'b0);
          end
          break;
        end
        fin = {2'b0, cur_time} + {17'd0, remain_q[r]};
        if (!bounded || fin <= target) begin
          cur_time = (fin > {2'b0, rms_pkg::TimeMax}) ? rms_pkg::TimeMax : fin[30:0];
          remain_q[r] = '0;
          push_event(rms_pkg::EV_COMPLETE, task_q[r], cur_time, wait_of(r), 1'b0);
          valid_q[r] = 1'b0;
          running = NoSlot;
          b = pick_slot();
          if (b != NoSlot) dispatch(b);
        end else begin
          remain_q[r] -= 16'(target - cur_time);
          cur_time = target[30:0];
          break;
        end
      end
    endfunction

    // Work out the events caused by one accepted input transaction.
    function void note_request(rms_pkg::req_t rq);
      bit [30:0] arr;
      int free_slot;
      if (rq.func == rms_pkg::FN_FINISH) begin
        advance('0, 1'b0);
        push_event(rms_pkg::EV_DONE, '0, cur_time, '0, 1'b1);
        return;
      end
      arr = (rq.arrival < cur_time) ? cur_time : rq.arrival;
      if (arr > cur_time) begin
        advance({1'b0, arr}, 1'b1);
        for (int i = 0; i < rms_pkg::TableDepth; i++) begin
          if (valid_q[i] && ({1'b0, arr_q[i]} + period_q[i] <= {1'b0, cur_time})) begin
            push_event(rms_pkg::EV_MISS, task_q[i], cur_time, wait_of(i), 1'b0);
            valid_q[i] = 1'b0;
            n_miss++;
            if (running == i) running = NoSlot;
          end
        end
      end
      free_slot = NoSlot;
      for (int i = 0; i < rms_pkg::TableDepth; i++) begin
        if (!valid_q[i]) begin
          free_slot = i;
          break;
        end
      end
      if (free_slot == NoSlot) begin
        push_event(rms_pkg::EV_OVERFLOW, rq.task_id, cur_time, '0, 1'b0);
        n_overflow++;
        return;
      end
      valid_q[free_slot]  = 1'b1;
      task_q[free_slot]   = rq.task_id;
      remain_q[free_slot] = rq.exec_time;
      exec_q[free_slot]   = rq.exec_time;
      period_q[free_slot] = rq.period;
      arr_q[free_slot]    = arr;
      intr_q[free_slot]   = 1'b0;
      age_q[free_slot]    = take_stamp();
    endfunction

    function void check_event(rms_pkg::res_t got);
      rms_pkg::res_t exp_ev;
      n_checked++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event %p", $time, got);
        errors++;
        return;
      end
      exp_ev = pending_events.pop_front();
      if (got.event_res !== exp_ev.event_res) begin
        $display("%0t: event_res exp %0d got %0d", $time, exp_ev.event_res, got.event_res);
        errors++;
      end
      if (got.job_task_id !== exp_ev.job_task_id) begin
        $display("%0t: job_task_id exp %0d got %0d", $time,
                 exp_ev.job_task_id, got.job_task_id);
        errors++;
      end
      if (got.event_time !== exp_ev.event_time) begin
        $display("%0t: event_time exp %0d got %0d", $time,
                 exp_ev.event_time, got.event_time);
        errors++;
      end
      if (got.waiting !== exp_ev.waiting) begin
        $display("%0t: waiting exp %0d got %0d", $time, exp_ev.waiting, got.waiting);
        errors++;
      end
      if (got.last !== exp_ev.last) begin
        $display("%0t: last exp %0b got %0b", $time, exp_ev.last, got.last);
        errors++;
      end
    endfunction
  endclass
endpackage

FILE: tb/testbench.sv
// Top-level testbench for rate_monotonic_scheduler_top: directed and random
// job releases with random stalls on both channels. Depends on rms_pkg,
// rms_if and rms_tb_pkg.
module testbench;

  logic clk_i;
  logic rst_ni;

  rms_req_if req_if ();
  rms_res_if res_if ();

  rate_monotonic_scheduler_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .res_o  (res_if.source)
  );

  rms_tb_pkg::sched_scoreboard sb;
  bit [30:0] arr_base;
  bit        stim_done;
  int        n_sent;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    clk_i = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    res_if.ready = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // valid stays high after acceptance until the next transaction or a gap
  task automatic send_request(bit fn, bit [15:0] tid, bit [15:0] ex,
                              bit [15:0] per, bit [30:0] arr);
    rms_pkg::req_t rq;
    int g;
    g = gap_len();
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    rq.func      = fn;
    rq.task_id   = tid;
    rq.exec_time = ex;
    rq.period    = per;
    rq.arrival   = arr;
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sb.note_request(rq);
    n_sent++;
  endtask

  task automatic release_job(bit [15:0] tid, bit [15:0] ex, bit [15:0] per,
                             bit [30:0] arr);
    send_request(rms_pkg::FN_RELEASE, tid, ex, per, arr);
  endtask

  task automatic finish_jobs();
    send_request(rms_pkg::FN_FINISH, 16'($urandom), 16'($urandom), 16'($urandom),
                 31'($urandom));
  endtask

  // Sink side: random stalls, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) sb.check_event(res_if.data);
      if ($urandom_range(0, 99) < 8) res_if.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 70) res_if.ready <= 1'b1;
    end
  end

  // A burst of releases over a short time window, then optionally a finish.
  task automatic job_burst(int n_jobs, bit with_finish);
    bit [15:0] ex, per;
    for (int i = 0; i < n_jobs; i++) begin
      if ($urandom_range(0, 3) != 0) arr_base = arr_base + 31'($urandom_range(0, 12));
      ex  = 16'($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 10));
      per = 16'($urandom_range(1, 30));
      if ($urandom_range(0, 19) == 0) begin
        ex  = 16'($urandom);
        per = 16'($urandom);
      end
      // occasional late arrival below the current time
      release_job(16'($urandom_range(1, 65535)), ex, per,
                  ($urandom_range(0, 14) == 0 && arr_base > 5) ? arr_base - 31'd5 : arr_base);
    end
    if (with_finish) begin
      finish_jobs();
      arr_base = sb.cur_time;
    end
  endtask

  initial begin
    sb = new();
    stim_done = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: same-time releases, tie in period, preemption, zero exec
    release_job(16'd1, 16'd5, 16'd20, 31'd0);
    release_job(16'd2, 16'd3, 16'd20, 31'd0);
    release_job(16'd3, 16'd0, 16'd10, 31'd1);
    release_job(16'd4, 16'd4, 16'd2, 31'd2);
    release_job(16'd65535, 16'd65535, 16'd65535, 31'd3);
    release_job(16'd6, 16'd2, 16'd1, 31'd40);
    release_job(16'd7, 16'd1, 16'd1, 31'd10);
    finish_jobs();
    // Full table: nine releases at one time
    for (int i = 0; i < 9; i++)
      release_job(16'(100 + i), 16'(i + 1), 16'(i % 3 + 5), sb.cur_time);
    release_job(16'd200, 16'd1, 16'd1, sb.cur_time + 31'd1000);
    finish_jobs();

    // Random part: bursts of releases relative to the current time
    arr_base = sb.cur_time;
    while (n_sent < 250) job_burst($urandom_range(3, 12), $urandom_range(0, 3) == 0);
    finish_jobs();

    // Time near the top: finish saturates
    release_job(16'd300, 16'd65535, 16'd65535, 31'h7FFF_FFF0);
    release_job(16'd301, 16'd65535, 16'd65535, 31'h7FFF_FFF8);
    finish_jobs();
    release_job(16'd302, 16'd1, 16'd1, 31'h7FFF_FFFF);
    finish_jobs();
    req_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d events (%0d preempts, %0d misses, %0d overflows).",
             n_sent, sb.n_checked, sb.n_preempt, sb.n_miss, sb.n_overflow);
    if (sb.errors == 0 && sb.pending_events.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #50000000;
    $display("Timeout with %0d events outstanding", sb.pending_events.size());
    $display("DONE: errors detected");
    $finish;
  end
endmodule
